@@ rtl/rssi_target_tracker_assert.svh @@
// Assertion macros shared by the tracker RTL.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef RSSI_TARGET_TRACKER_ASSERT_SVH
`define RSSI_TARGET_TRACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define RTT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tracker check failed in the same cycle");
// Next-cycle implication, disabled while reset is asserted.
`define RTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tracker check failed one cycle later");
`else
`define RTT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/rtt_pkg.sv @@
// Types, constants and percent helper for the RSSI target tracker.
// No dependencies; used by rtt_track, rtt_report and rssi_target_tracker.
package rtt_pkg;

  typedef logic signed [7:0] rssi_t;
  typedef logic [6:0] pct_t;

  typedef enum logic [1:0] {
    OP_SCAN    = 2'd0,
    OP_RESTART = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PROX_SEARCH     = 3'd0,
    PROX_FAR        = 3'd1,
    PROX_NEAR       = 3'd2,
    PROX_CLOSE      = 3'd3,
    PROX_VERY_CLOSE = 3'd4
  } prox_t;

  typedef enum logic [1:0] {
    SIG_STRONG = 2'd0,
    SIG_FAIR   = 2'd1,
    SIG_WEAK   = 2'd2,
    SIG_POOR   = 2'd3
  } sig_t;

  typedef enum logic [1:0] {
    TREND_SEARCHING   = 2'd0,
    TREND_STABLE      = 2'd1,
    TREND_APPROACHING = 2'd2,
    TREND_AWAY        = 2'd3
  } trend_cls_t;

  typedef enum logic [1:0] {
    LVL_EMPTY  = 2'd0,
    LVL_LOW    = 2'd1,
    LVL_MEDIUM = 2'd2,
    LVL_HIGH   = 2'd3
  } level_t;

  // Tracker state plus the registered history read, as seen by the report stage.
  typedef struct packed {
    logic        seen;
    rssi_t       rssi;
    rssi_t       peak;
    rssi_t       trend;
    logic [31:0] count;
    logic        is_read;
    logic        hist_hit;
    rssi_t       hist_sample;
  } rtt_status_t;

  localparam rssi_t RSSI_MIN    = -8'sd127;
  localparam rssi_t RSSI_MAX    = 8'sd0;
  localparam rssi_t SEEN_FLOOR  = -8'sd120;
  localparam rssi_t LOST_TREND  = -8'sd8;
  localparam rssi_t LOST_SAMPLE = -8'sd100;
  localparam rssi_t TREND_RESET = 8'sd0;
  localparam rssi_t PCT_FLOOR   = -8'sd100;
  localparam rssi_t PCT_CEIL    = -8'sd35;
  localparam rssi_t SIG_STRONG_MIN = -8'sd58;
  localparam rssi_t SIG_FAIR_MIN   = -8'sd74;
  localparam rssi_t SIG_WEAK_MIN   = -8'sd88;
  localparam rssi_t TREND_UP_MIN   = 8'sd4;
  localparam rssi_t TREND_DOWN_MAX = -8'sd4;

  localparam pct_t PCT_FULL      = 7'd100;
  localparam pct_t PROX_VC_MIN   = 7'd76;
  localparam pct_t PROX_CLOSE_MIN = 7'd52;
  localparam pct_t PROX_NEAR_MIN = 7'd28;
  localparam pct_t LVL_HIGH_ABOVE = 7'd70;
  localparam pct_t LVL_MED_ABOVE = 7'd38;

  localparam int PCT_SPAN = 65;
  localparam int PCT_LUT_LAST = 64;

  typedef logic [PCT_LUT_LAST:0][6:0] pct_lut_t;

  // Percent for each offset above the floor, built at elaboration.
  function automatic pct_lut_t build_pct_lut();
    pct_lut_t t;
    for (int i = 0; i <= PCT_LUT_LAST; i++) begin
      t[i] = pct_t'((i * 100) / PCT_SPAN);
    end
    return t;
  endfunction

  localparam pct_lut_t PCT_LUT = build_pct_lut();

  function automatic pct_t pct_of(rssi_t r);
    rssi_t ofs;
    ofs = r - PCT_FLOOR;
    if (r <= PCT_FLOOR) begin
      return '0;
    end else if (r >= PCT_CEIL) begin
      return PCT_FULL;
    end else begin
      return PCT_LUT[ofs[6:0]];
    end
  endfunction

endpackage

@@ rtl/rtt_track.sv @@
// Tracker state and sample ring: updates on every accepted transaction.
// Depends on rtt_pkg.
module rtt_track #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [1:0]          opcode,
  input  logic                found,
  input  logic signed [7:0]   rssi,
  input  logic [4:0]          age_index,
  output rtt_pkg::rtt_status_t status
);
  import rtt_pkg::*;

  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  rssi_t           rssi_r, peak_r, trend_r;
  logic            seen_r;
  logic [31:0]     count_r;
  logic [HW-1:0]   head_r, head_inc;
  logic [HISTORY_DEPTH-1:0] filled_r;
  logic            is_read_r, hit_r;
  rssi_t           rd_data_r;

  rssi_t           ring_mem [HISTORY_DEPTH];

  rssi_t           r_sat, wr_data;
  logic signed [8:0] diff;
  rssi_t           trend_new;
  logic            in_range, rd_hit;
  logic [7:0]      rd_sum;
  logic [HW-1:0]   rd_idx;
  logic            wr_en;

  always_comb begin
    // Clamp the reading to -127..0.
    if (rssi > RSSI_MAX) r_sat = RSSI_MAX;
    else if (rssi < RSSI_MIN) r_sat = RSSI_MIN;
    else r_sat = rssi;

    diff = $signed({r_sat[7], r_sat}) - $signed({rssi_r[7], rssi_r});
    if (rssi_r < SEEN_FLOOR) trend_new = TREND_RESET;
    else if (diff > 9'sd127) trend_new = 8'sd127;
    else if (diff < -9'sd127) trend_new = RSSI_MIN;
    else trend_new = diff[7:0];

    wr_data = found ? r_sat : LOST_SAMPLE;
    wr_en = acc && (opcode == OP_SCAN);

    head_inc = (head_r == HW'(HISTORY_DEPTH - 1)) ? '0 : head_r + 1'b1;

    // Age 0 is the oldest slot, which is the next one to be overwritten.
    in_range = {2'b00, age_index} < 7'(HISTORY_DEPTH);
    rd_sum = 8'(head_r) + {3'b000, age_index};
    if (rd_sum >= 8'(HISTORY_DEPTH)) rd_sum = rd_sum - 8'(HISTORY_DEPTH);
    rd_idx = rd_sum[HW-1:0];
    rd_hit = in_range && filled_r[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rssi_r    <= RSSI_MIN;
      seen_r    <= 1'b0;
      peak_r    <= RSSI_MIN;
      trend_r   <= TREND_RESET;
      count_r   <= '0;
      head_r    <= '0;
      filled_r  <= '0;
      is_read_r <= 1'b0;
      hit_r     <= 1'b0;
    end else if (acc) begin
      is_read_r <= (opcode == OP_READ);
      hit_r     <= rd_hit;
      case (opcode)
        OP_SCAN: begin
          count_r <= count_r + 32'd1;
          seen_r  <= found;
          head_r  <= head_inc;
          filled_r[head_r] <= 1'b1;
          if (found) begin
            rssi_r  <= r_sat;
            trend_r <= trend_new;
            if (peak_r < SEEN_FLOOR || r_sat > peak_r) peak_r <= r_sat;
          end else begin
            rssi_r  <= RSSI_MIN;
            trend_r <= LOST_TREND;
          end
        end
        OP_RESTART: begin
          rssi_r   <= RSSI_MIN;
          seen_r   <= 1'b0;
          peak_r   <= RSSI_MIN;
          trend_r  <= TREND_RESET;
          count_r  <= '0;
          head_r   <= '0;
          filled_r <= '0;
        end
        default: begin
          // Read and the unused opcode leave the state alone.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[head_r] <= wr_data;
    if (acc) rd_data_r <= ring_mem[rd_idx];
  end

  assign status = '{
    seen:        seen_r,
    rssi:        rssi_r,
    peak:        peak_r,
    trend:       trend_r,
    count:       count_r,
    is_read:     is_read_r,
    hist_hit:    hit_r,
    hist_sample: rd_data_r
  };

endmodule

@@ rtl/rtt_report.sv @@
// Result stage: classifies the tracker status and holds the result register.
// Depends on rtt_pkg.
module rtt_report (
  input  logic                clk,
  input  logic                load,
  input  rtt_pkg::rtt_status_t status,
  output logic                seen,
  output logic signed [7:0]   current_rssi,
  output logic [6:0]          strength_pct,
  output logic [2:0]          proximity,
  output logic [1:0]          signal_class,
  output logic signed [7:0]   trend_db,
  output logic [1:0]          trend_class,
  output logic signed [7:0]   peak_rssi,
  output logic [31:0]         scan_count,
  output logic signed [7:0]   history_sample,
  output logic [6:0]          history_pct,
  output logic [1:0]          history_level
);
  import rtt_pkg::*;

  pct_t       pct_nxt, hpct_nxt;
  prox_t      prox_nxt;
  sig_t       sig_nxt;
  trend_cls_t tcl_nxt;
  level_t     lvl_nxt;
  rssi_t      hs_nxt;

  pct_t       pct_r, hpct_r;
  prox_t      prox_r;
  sig_t       sig_r;
  trend_cls_t tcl_r;
  level_t     lvl_r;
  rssi_t      hs_r, rssi_r, trend_r, peak_r;
  logic       seen_r;
  logic [31:0] count_r;

  always_comb begin
    if (status.seen) begin
      pct_nxt = pct_of(status.rssi);
      if (pct_nxt >= PROX_VC_MIN) prox_nxt = PROX_VERY_CLOSE;
      else if (pct_nxt >= PROX_CLOSE_MIN) prox_nxt = PROX_CLOSE;
      else if (pct_nxt >= PROX_NEAR_MIN) prox_nxt = PROX_NEAR;
      else prox_nxt = PROX_FAR;
      if (status.rssi >= SIG_STRONG_MIN) sig_nxt = SIG_STRONG;
      else if (status.rssi >= SIG_FAIR_MIN) sig_nxt = SIG_FAIR;
      else if (status.rssi >= SIG_WEAK_MIN) sig_nxt = SIG_WEAK;
      else sig_nxt = SIG_POOR;
      if (status.trend >= TREND_UP_MIN) tcl_nxt = TREND_APPROACHING;
      else if (status.trend <= TREND_DOWN_MAX) tcl_nxt = TREND_AWAY;
      else tcl_nxt = TREND_STABLE;
    end else begin
      pct_nxt  = '0;
      prox_nxt = PROX_SEARCH;
      sig_nxt  = SIG_POOR;
      tcl_nxt  = TREND_SEARCHING;
    end

    // A zero sample marks an empty slot.
    hs_nxt = (status.is_read && status.hist_hit) ? status.hist_sample : '0;
    if (hs_nxt != '0) begin
      hpct_nxt = pct_of(hs_nxt);
      if (hpct_nxt > LVL_HIGH_ABOVE) lvl_nxt = LVL_HIGH;
      else if (hpct_nxt > LVL_MED_ABOVE) lvl_nxt = LVL_MEDIUM;
      else lvl_nxt = LVL_LOW;
    end else begin
      hpct_nxt = '0;
      lvl_nxt  = LVL_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seen_r  <= status.seen;
      rssi_r  <= status.rssi;
      pct_r   <= pct_nxt;
      prox_r  <= prox_nxt;
      sig_r   <= sig_nxt;
      trend_r <= status.trend;
      tcl_r   <= tcl_nxt;
      peak_r  <= status.peak;
      count_r <= status.count;
      hs_r    <= hs_nxt;
      hpct_r  <= hpct_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

  assign seen           = seen_r;
  assign current_rssi   = rssi_r;
  assign strength_pct   = pct_r;
  assign proximity      = prox_r;
  assign signal_class   = sig_r;
  assign trend_db       = trend_r;
  assign trend_class    = tcl_r;
  assign peak_rssi      = peak_r;
  assign scan_count     = count_r;
  assign history_sample = hs_r;
  assign history_pct    = hpct_r;
  assign history_level  = lvl_r;

endmodule

@@ rtl/rssi_target_tracker.sv @@
// Top level of the RSSI target tracker: handshake control and two stages.
// Depends on rtt_pkg, rtt_track, rtt_report and rssi_target_tracker_assert.svh.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in_     | to block  | in_valid / in_stall | opcode, found, rssi, age_index
//   out_    | from block| out_valid/out_stall | seen .. scan_count, history_sample/pct/level
//
// One transaction per clock sustained while out_stall stays low; a result reaches
// the output ports by way of the tracker state and history read, registered at the
// accept edge, and then the result register, which loads once it is free.
// Synchronous active-low reset clears all tracker state; history slots carry
// one valid flag each, so there is no clearing pass and input is taken at once.
// in_stall rises only when the tracker stage holds a transaction and the result
// register is full and stalled; a taken result frees the path in the same cycle.
`include "rssi_target_tracker_assert.svh"
module rssi_target_tracker #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic              in_found,
  input  logic signed [7:0] in_rssi,
  input  logic [4:0]        in_age_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_seen,
  output logic signed [7:0] out_current_rssi,
  output logic [6:0]        out_strength_pct,
  output logic [2:0]        out_proximity,
  output logic [1:0]        out_signal_class,
  output logic signed [7:0] out_trend_db,
  output logic [1:0]        out_trend_class,
  output logic signed [7:0] out_peak_rssi,
  output logic [31:0]       out_scan_count,
  output logic signed [7:0] out_history_sample,
  output logic [6:0]        out_history_pct,
  output logic [1:0]        out_history_level
);
  import rtt_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        acc, adv;
  rtt_status_t status;

  // Advance the tracker stage whenever the result register is free or drains now.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  // Hold the input only when the tracker stage cannot move on.
  assign in_stall = s1_valid_r && !adv;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // State update and history read happen at the accept edge.
  rtt_track #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .opcode   (in_opcode),
    .found    (in_found),
    .rssi     (in_rssi),
    .age_index(in_age_index),
    .status   (status)
  );

  // Classify the post-update status into the result register.
  rtt_report u_report (
    .clk           (clk),
    .load          (adv),
    .status        (status),
    .seen          (out_seen),
    .current_rssi  (out_current_rssi),
    .strength_pct  (out_strength_pct),
    .proximity     (out_proximity),
    .signal_class  (out_signal_class),
    .trend_db      (out_trend_db),
    .trend_class   (out_trend_class),
    .peak_rssi     (out_peak_rssi),
    .scan_count    (out_scan_count),
    .history_sample(out_history_sample),
    .history_pct   (out_history_pct),
    .history_level (out_history_level)
  );

  `RTT_ASSERT_SAME(a_stall_has_work, clk, rst_n, in_stall, s1_valid_r && out_valid_r)
  `RTT_ASSERT_NEXT(a_restart_clears, clk, rst_n, acc && in_opcode == OP_RESTART,
    !status.seen && status.count == '0 && status.peak == RSSI_MIN)
  `RTT_ASSERT_NEXT(a_found_scan_seen, clk, rst_n, acc && in_opcode == OP_SCAN && in_found,
    status.seen && !status.is_read)
  `RTT_ASSERT_SAME(a_empty_hist_zero, clk, rst_n, out_valid && out_history_level == LVL_EMPTY,
    out_history_pct == '0 && out_history_sample == '0)

endmodule

@@ test/tb_rssi_target_tracker.sv @@
// Self-checking bench for rssi_target_tracker: scan, restart and history-read traffic.
// Needs rtt_pkg and the tracker RTL; the expected status comes from a model in this file.
`timescale 1ns / 100ps

module tb_rssi_target_tracker;
  import rtt_pkg::*;

  localparam int HIST_DEPTH    = 32;
  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int IDLE_PCT      = 34;
  localparam int REPORT_MAX    = 10;
  localparam int TREND_LIMIT   = 127;
  // The one opcode the package leaves unnamed: the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Cycle window with no idling on either side.
  localparam int QUIET_FROM    = 600;
  localparam int QUIET_TO      = 1200;
  // Receiver hold-off that backs the pipeline up into the input.
  localparam int HOLD_AT       = 1500;
  localparam int HOLD_CYCLES   = 400;

  // One input transaction.
  typedef struct packed {
    logic [1:0] opcode;
    logic       found;
    rssi_t      rssi;
    logic [4:0] age;
  } scan_item_t;

  // One result transaction, fields in port order.
  typedef struct packed {
    logic        seen;
    rssi_t       rssi;
    pct_t        pct;
    prox_t       prox;
    sig_t        sig;
    rssi_t       trend;
    trend_cls_t  trend_cls;
    rssi_t       peak;
    logic [31:0] scans;
    rssi_t       hist_sample;
    pct_t        hist_pct;
    level_t      hist_level;
  } tracker_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_opcode = OP_SCAN;
  logic              in_found = 1'b0;
  logic signed [7:0] in_rssi = '0;
  logic [4:0]        in_age_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_seen;
  logic signed [7:0] out_current_rssi;
  logic [6:0]        out_strength_pct;
  logic [2:0]        out_proximity;
  logic [1:0]        out_signal_class;
  logic signed [7:0] out_trend_db;
  logic [1:0]        out_trend_class;
  logic signed [7:0] out_peak_rssi;
  logic [31:0]       out_scan_count;
  logic signed [7:0] out_history_sample;
  logic [6:0]        out_history_pct;
  logic [1:0]        out_history_level;

  rssi_target_tracker #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_found          (in_found),
    .in_rssi           (in_rssi),
    .in_age_index      (in_age_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_seen          (out_seen),
    .out_current_rssi  (out_current_rssi),
    .out_strength_pct  (out_strength_pct),
    .out_proximity     (out_proximity),
    .out_signal_class  (out_signal_class),
    .out_trend_db      (out_trend_db),
    .out_trend_class   (out_trend_class),
    .out_peak_rssi     (out_peak_rssi),
    .out_scan_count    (out_scan_count),
    .out_history_sample(out_history_sample),
    .out_history_pct   (out_history_pct),
    .out_history_level (out_history_level)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Free-running cycle count: drives the quiet window, the hold-off and the timeout.
  int unsigned cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  wire quiet_stretch = cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO;

  // ---------------------------------------------------------------------------
  // Tracker model: its own copy of the tracking state and the sample ring.
  // ---------------------------------------------------------------------------
  logic              trk_seen;
  rssi_t             trk_rssi;
  rssi_t             trk_peak;
  rssi_t             trk_trend;
  logic [31:0]       scan_total;
  rssi_t             ring [HIST_DEPTH];
  int                ring_wr;

  function automatic void clear_tracker();
    trk_seen   = 1'b0;
    trk_rssi   = RSSI_MIN;
    trk_peak   = RSSI_MIN;
    trk_trend  = TREND_RESET;
    scan_total = '0;
    ring_wr    = 0;
    for (int i = 0; i < HIST_DEPTH; i++) ring[i] = '0;
  endfunction

  // Strength in percent over the linear span between the floor and the ceiling.
  function automatic int strength_of(int r);
    if (r <= PCT_FLOOR) return 0;
    if (r >= PCT_CEIL) return PCT_FULL;
    return ((r - int'(PCT_FLOOR)) * int'(PCT_FULL)) / PCT_SPAN;
  endfunction

  function automatic void push_sample(int v);
    ring[ring_wr] = rssi_t'(v);
    ring_wr = (ring_wr + 1) % HIST_DEPTH;
  endfunction

  // Apply one transaction to the model and return the status it must produce.
  function automatic tracker_status_t track_item(scan_item_t it);
    tracker_status_t s;
    int r, prev, t, p, slot;
    s = '0;
    r = it.rssi;
    // Clamp the reported RSSI into the legal dBm range first.
    if (r > RSSI_MAX) r = RSSI_MAX;
    if (r < RSSI_MIN) r = RSSI_MIN;
    case (it.opcode)
      OP_SCAN: begin
        prev = trk_rssi;
        scan_total = scan_total + 1;
        trk_seen = it.found;
        if (it.found) begin
          trk_rssi = rssi_t'(r);
          if (trk_peak < SEEN_FLOOR || r > trk_peak) trk_peak = rssi_t'(r);
          // No trend on the first reading after a loss or a restart.
          t = (prev < SEEN_FLOOR) ? 0 : r - prev;
          if (t > TREND_LIMIT) t = TREND_LIMIT;
          if (t < -TREND_LIMIT) t = -TREND_LIMIT;
          trk_trend = rssi_t'(t);
          push_sample(r);
        end else begin
          trk_rssi = RSSI_MIN;
          trk_trend = LOST_TREND;
          push_sample(LOST_SAMPLE);
        end
      end
      OP_RESTART: clear_tracker();
      OP_READ: begin
        if (it.age < HIST_DEPTH) begin
          // Age 0 is the oldest slot, which is the next one to be overwritten.
          slot = (ring_wr + it.age) % HIST_DEPTH;
          s.hist_sample = ring[slot];
          if (ring[slot] != 0) begin
            p = strength_of(ring[slot]);
            s.hist_pct = pct_t'(p);
            s.hist_level = p > LVL_HIGH_ABOVE ? LVL_HIGH :
                           p > LVL_MED_ABOVE  ? LVL_MEDIUM : LVL_LOW;
          end
        end
      end
      default: ;
    endcase

    s.seen  = trk_seen;
    s.rssi  = trk_rssi;
    s.trend = trk_trend;
    s.peak  = trk_peak;
    s.scans = scan_total;
    if (trk_seen) begin
      p = strength_of(trk_rssi);
      s.pct  = pct_t'(p);
      s.prox = p >= PROX_VC_MIN    ? PROX_VERY_CLOSE :
               p >= PROX_CLOSE_MIN ? PROX_CLOSE :
               p >= PROX_NEAR_MIN  ? PROX_NEAR : PROX_FAR;
      s.sig  = trk_rssi >= SIG_STRONG_MIN ? SIG_STRONG :
               trk_rssi >= SIG_FAIR_MIN   ? SIG_FAIR :
               trk_rssi >= SIG_WEAK_MIN   ? SIG_WEAK : SIG_POOR;
      s.trend_cls = trk_trend >= TREND_UP_MIN   ? TREND_APPROACHING :
                    trk_trend <= TREND_DOWN_MAX ? TREND_AWAY : TREND_STABLE;
    end else begin
      s.pct       = '0;
      s.prox      = PROX_SEARCH;
      s.sig       = SIG_POOR;
      s.trend_cls = TREND_SEARCHING;
    end
    return s;
  endfunction

  function automatic string show(tracker_status_t s);
    return $sformatf({"seen=%0d rssi=%0d pct=%0d prox=%0d sig=%0d trend=%0d tcls=%0d ",
                      "peak=%0d scans=%0d hist=%0d pct=%0d lvl=%0d"},
                     s.seen, s.rssi, s.pct, s.prox, s.sig, s.trend, s.trend_cls,
                     s.peak, s.scans, s.hist_sample, s.hist_pct, s.hist_level);
  endfunction

  // Names of the fields that differ, empty when the transaction matches.
  function automatic string diff_fields(tracker_status_t w, tracker_status_t g);
    string bad;
    bad = "";
    if (w.seen !== g.seen)               bad = {bad, " seen"};
    if (w.rssi !== g.rssi)               bad = {bad, " current_rssi"};
    if (w.pct !== g.pct)                 bad = {bad, " strength_pct"};
    if (w.prox !== g.prox)               bad = {bad, " proximity"};
    if (w.sig !== g.sig)                 bad = {bad, " signal_class"};
    if (w.trend !== g.trend)             bad = {bad, " trend_db"};
    if (w.trend_cls !== g.trend_cls)     bad = {bad, " trend_class"};
    if (w.peak !== g.peak)               bad = {bad, " peak_rssi"};
    if (w.scans !== g.scans)             bad = {bad, " scan_count"};
    if (w.hist_sample !== g.hist_sample) bad = {bad, " history_sample"};
    if (w.hist_pct !== g.hist_pct)       bad = {bad, " history_pct"};
    if (w.hist_level !== g.hist_level)   bad = {bad, " history_level"};
    return bad;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus queue and expected-status queue.
  // ---------------------------------------------------------------------------
  scan_item_t      pending_items[$];
  tracker_status_t expected_status[$];
  int              fail_cnt = 0;

  function automatic void add_item(logic [1:0] op, logic found, int rssi, int age);
    scan_item_t it;
    it.opcode = op;
    it.found  = found;
    it.rssi   = rssi_t'(rssi);
    it.age    = 5'(age);
    pending_items.push_back(it);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: hold the offered transaction until it is taken, then either idle
  // or advance to the next pending item. The model runs at acceptance.
  // ---------------------------------------------------------------------------
  scan_item_t cur_item;

  always @(posedge clk) begin
    bit offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_status.push_back(track_item(cur_item));
      end
      // Drive a new transaction only when the lane is free; hold it otherwise.
      if (!in_valid || !in_stall) begin
        offer = pending_items.size() != 0 &&
                (quiet_stretch || $urandom_range(99) >= IDLE_PCT);
        if (offer) begin
          cur_item = pending_items.pop_front();
          in_opcode    <= cur_item.opcode;
          in_found     <= cur_item.found;
          in_rssi      <= cur_item.rssi;
          in_age_index <= cur_item.age;
        end
        in_valid <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver hold-off: once, stall the result side for a long stretch while
  // the driver keeps offering, so both stages fill and in_stall rises.
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && cycle_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each taken result against the oldest expectation, then
  // pick the stall for the next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tracker_status_t want, got;
    string bad;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_seen, out_current_rssi, out_strength_pct, out_proximity,
               out_signal_class, out_trend_db, out_trend_class, out_peak_rssi,
               out_scan_count, out_history_sample, out_history_pct, out_history_level};
        if (expected_status.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("result with nothing expected: %s", show(got));
        end else begin
          want = expected_status.pop_front();
          bad = diff_fields(want, got);
          if (bad != "") begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
              $display("wrong%s\n  expected %s\n  actual   %s", bad, show(want), show(got));
          end
        end
      end
      out_stall <= hold_left != 0 || (!quiet_stretch && $urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the stimulus, reset once, wait for the drain, judge.
  // ---------------------------------------------------------------------------
  initial begin
    int   walk, k, v;
    bit   timed_out;
    scan_item_t it;

    clear_tracker();

    // Directed part. Reads on an empty ring first.
    add_item(OP_READ, 1'b0, 0, 0);
    add_item(OP_READ, 1'b1, 0, 31);
    // First sighting at the floor, then a jump to the ceiling: no trend yet.
    add_item(OP_SCAN, 1'b1, -127, 0);
    add_item(OP_SCAN, 1'b1, 0, 0);
    // Full swing down, back up from the seen floor itself.
    add_item(OP_SCAN, 1'b1, -127, 0);
    add_item(OP_SCAN, 1'b1, -120, 0);
    add_item(OP_SCAN, 1'b1, 0, 0);
    // Out-of-range RSSI values clamp to the legal range.
    add_item(OP_SCAN, 1'b1, 127, 0);
    add_item(OP_SCAN, 1'b1, -128, 0);
    // Lost scan with junk in the RSSI field.
    add_item(OP_SCAN, 1'b0, 8'h55, 7);
    // Percent and signal-class boundaries.
    add_item(OP_SCAN, 1'b1, -35, 0);
    add_item(OP_SCAN, 1'b1, -36, 0);
    add_item(OP_SCAN, 1'b1, -99, 0);
    add_item(OP_SCAN, 1'b1, -100, 0);
    add_item(OP_SCAN, 1'b1, -58, 0);
    add_item(OP_SCAN, 1'b1, -59, 0);
    add_item(OP_SCAN, 1'b1, -74, 0);
    add_item(OP_SCAN, 1'b1, -88, 0);
    add_item(OP_SCAN, 1'b1, -89, 0);
    // Unused opcode leaves the state alone.
    add_item(OP_UNUSED, 1'b1, -50, 5);
    // Oldest (empty), the first sample, a zero sample, and the newest.
    add_item(OP_READ, 1'b0, 0, 0);
    add_item(OP_READ, 1'b0, 0, 15);
    add_item(OP_READ, 1'b0, 0, 16);
    add_item(OP_READ, 1'b0, 0, 31);
    // Restart clears the ring as well.
    add_item(OP_RESTART, 1'b0, 0, 0);
    add_item(OP_READ, 1'b0, 0, 31);

    // Random part: mostly scans that drift like a moving target, with reads
    // spread over every age and rare restarts and unused opcodes as noise.
    walk = -70;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      k = $urandom_range(99);
      it.age   = 5'($urandom_range(HIST_DEPTH - 1));
      it.found = 1'($urandom);
      it.rssi  = rssi_t'($urandom);
      if (k < 2) begin
        it.opcode = OP_RESTART;
      end else if (k < 4) begin
        it.opcode = OP_UNUSED;
      end else if (k < 28) begin
        it.opcode = OP_READ;
      end else begin
        it.opcode = OP_SCAN;
        it.found  = $urandom_range(99) >= 15;
        v = $urandom_range(99);
        if (v < 60) begin
          walk = walk + $urandom_range(12) - 6;
          if (walk > RSSI_MAX) walk = RSSI_MAX;
          if (walk < RSSI_MIN) walk = RSSI_MIN;
          it.rssi = rssi_t'(walk);
        end else if (v < 92) begin
          it.rssi = rssi_t'(-int'($urandom_range(127)));
        end
      end
      pending_items.push_back(it);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so the clocked processes have all settled.
    while (cycle_cnt < CYCLE_LIMIT &&
           (pending_items.size() != 0 || in_valid || expected_status.size() != 0))
      @(negedge clk);
    timed_out = cycle_cnt >= CYCLE_LIMIT;
    // Give a stray extra result time to show up.
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (!timed_out && fail_cnt == 0 && expected_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rtt_pkg.sv
rtl/rtt_track.sv
rtl/rtt_report.sv
rtl/rssi_target_tracker.sv
test/tb_rssi_target_tracker.sv
